>>> hw/rtl/pft_pkg.sv
// ----------------------------------------------------------------------------
// pft_pkg: shared definitions for the planar frame transform
// Widths, fixed-point constants, register indexes and the constant tables
// used by the angle conversion and the rotation pipeline.
// ----------------------------------------------------------------------------
package pft_pkg;

  // Default sizes handed to the top level.
  localparam int DEF_COORD_WIDTH     = 24;
  localparam int DEF_ROTATION_STAGES = 16;

  // Fixed field widths.
  localparam int ANGLE_WIDTH     = 15;
  localparam int HEADING_WIDTH   = 16;
  localparam int REG_INDEX_WIDTH = 2;
  localparam int ZW              = 32;  // binary angle width, full turn = 2^32

  // Guard fraction bits carried below the coordinate fraction bits.
  localparam int GUARD_BITS = 16;

  // Pipeline stages ahead of the rotation (difference, gain, angle, fold),
  // plus the rounding and saturation stage behind it.
  localparam int PRE_STAGES  = 4;
  localparam int PIPE_EXTRA  = PRE_STAGES + 1;

  // Angle units: 1/32 degree, full turn is two half turns.
  localparam int HALF_TURN_DEG = 180;
  localparam int FULL_TURN     = 2 * HALF_TURN_DEG * 32;  // 11520
  // 2^32 / FULL_TURN = 2^24 / ANGLE_DIV, since FULL_TURN = 256 * ANGLE_DIV.
  localparam int ANGLE_DIV     = FULL_TURN / 256;          // 45
  localparam int FRAC_BITS     = ZW - 8;                   // 24
  localparam int FRAC_BIAS     = (FULL_TURN / 2) / 256;    // rounding term, 22
  // Reciprocal of ANGLE_DIV, exact for every reduced angle below FULL_TURN.
  localparam int Q_SHIFT       = 19;
  localparam int Q_RECIP       = (2 ** Q_SHIFT + ANGLE_DIV - 1) / ANGLE_DIV;
  localparam int R_WIDTH       = 14;  // reduced angle, 0 .. FULL_TURN-1
  localparam int Q_WIDTH       = 8;   // reduced angle / ANGLE_DIV
  localparam int M_WIDTH       = 6;   // remainder, 0 .. ANGLE_DIV-1

  // Inverse CORDIC gain, 30 fraction bits.
  localparam logic signed [30:0] KINV_Q30  = 31'sh26DD3B6A;
  localparam int                 KINV_FRAC = 30;

  localparam logic [ZW-1:0] HALF_CIRCLE = 32'h8000_0000;

  // Configuration register indexes.
  typedef enum logic [REG_INDEX_WIDTH-1:0] {
    REG_ORIGIN_X    = 2'd0,
    REG_ORIGIN_Y    = 2'd1,
    REG_FRAME_ANGLE = 2'd2
  } cfg_reg_e;

  // atan(2^-i) as a binary angle.
  localparam int ATAN_ENTRIES = 24;
  typedef logic [ZW-1:0] atan_table_t [ATAN_ENTRIES];
  localparam atan_table_t ATAN_TABLE = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Low part of the binary angle for each remainder of the reduced angle.
  typedef logic [FRAC_BITS-1:0] frac_lut_t [ANGLE_DIV];

  function automatic frac_lut_t build_frac_lut();
    frac_lut_t lut;
    longint    num;
    for (int m = 0; m < ANGLE_DIV; m++) begin
      num    = (longint'(m) <<< FRAC_BITS) + longint'(FRAC_BIAS);
      lut[m] = FRAC_BITS'(num / ANGLE_DIV);
    end
    return lut;
  endfunction

  localparam frac_lut_t FRAC_LUT = build_frac_lut();

endpackage

>>> hw/rtl/pft_if.sv
// ----------------------------------------------------------------------------
// pft_if: word channels of the planar frame transform
// One channel carries input poses, the other carries transformed poses.
// ----------------------------------------------------------------------------
interface pft_pose_if
  import pft_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [ANGLE_WIDTH-1:0] heading;

  modport source (output valid, output pos_x, output pos_y, output heading, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

interface pft_result_if
  import pft_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) ();
  logic                            valid;
  logic                            ready;
  logic signed [COORD_WIDTH-1:0]   new_x;
  logic signed [COORD_WIDTH-1:0]   new_y;
  logic signed [HEADING_WIDTH-1:0] new_heading;

  modport source (output valid, output new_x, output new_y, output new_heading,
                  input ready);
  modport sink   (input valid, input new_x, input new_y, input new_heading,
                  output ready);
endinterface

>>> hw/rtl/planar_frame_transform.sv
// ----------------------------------------------------------------------------
// planar_frame_transform: pose expressed in a configured frame
// Subtracts the frame origin, rotates by minus the frame angle with a
// pipelined CORDIC and subtracts the frame angle from the heading.
// ----------------------------------------------------------------------------
// Usage. Poses arrive on pose_in as words of (pos_x, pos_y, heading) and leave
// on pose_out as words of (new_x, new_y, new_heading); a word moves when valid
// and ready are both high at a rising edge of clk. Every input word gives
// exactly one output word, in order.
// The configuration port writes origin_x (index 0), origin_y (index 1) and
// frame_angle (index 2) when cfg_write is high; other indexes are ignored.
// Write it only while no word is in flight.
// The pipeline has four stages for the origin difference, the gain multiply,
// the angle conversion and the quadrant fold, one stage per CORDIC iteration,
// and the rounding stage, which is the output register. One word is accepted
// every cycle while the output is not stalled; the multiplier in the gain
// stage and the CORDIC adders set the clock.
// Each stage has its own valid bit and loads whenever it is empty or the
// stage behind it moves on, so a stalled receiver holds the output word while
// empty stages further up keep accepting words; nothing is dropped or
// repeated. A synchronous reset empties the pipeline and clears the
// configuration registers to zero.
// ----------------------------------------------------------------------------
module planar_frame_transform
  import pft_pkg::*;
#(
  parameter int COORD_WIDTH     = DEF_COORD_WIDTH,
  parameter int ROTATION_STAGES = DEF_ROTATION_STAGES,
  localparam int DATA_WIDTH     = (COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [REG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]      cfg_data,
  pft_pose_if.sink                   pose_in,
  pft_result_if.source               pose_out
);

  // Difference width, CORDIC datapath width and product width.
  localparam int DW    = COORD_WIDTH + 1;
  localparam int CW    = COORD_WIDTH + 18;
  localparam int PW    = DW + 31;
  localparam int SH    = KINV_FRAC - GUARD_BITS;
  localparam int NST   = ROTATION_STAGES + PIPE_EXTRA;
  localparam int OUT_S = NST - 1;
  localparam int RW    = CW + 1 - GUARD_BITS;

  localparam logic signed [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [CW:0]            RND     = (CW+1)'(1) <<< (GUARD_BITS - 1);
  localparam logic signed [15:0]            TURN16  = 16'(FULL_TURN);

  // Configuration registers.
  logic signed [COORD_WIDTH-1:0] origin_x;
  logic signed [COORD_WIDTH-1:0] origin_y;
  logic signed [ANGLE_WIDTH-1:0] frame_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      frame_angle <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_ORIGIN_X:    origin_x    <= cfg_data[COORD_WIDTH-1:0];
        REG_ORIGIN_Y:    origin_y    <= cfg_data[COORD_WIDTH-1:0];
        REG_FRAME_ANGLE: frame_angle <= cfg_data[ANGLE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Flow control: a stage loads when it is empty or its successor loads.
  logic [NST:0]   rdy;
  logic [NST-1:0] vld;
  logic [NST-1:0] vld_in;

  assign rdy[NST] = pose_out.ready;
  for (genvar j = 0; j < NST; j++) begin : g_rdy
    assign rdy[j] = ~vld[j] | rdy[j+1];
  end
  assign vld_in        = {vld[NST-2:0], pose_in.valid};
  assign pose_in.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (rdy[NST-1:0] & vld_in) | (~rdy[NST-1:0] & vld);
    end
  end

  // The heading difference rides along with every stage.
  logic signed [HEADING_WIDTH-1:0] hd [NST];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      hd[0] <= {pose_in.heading[ANGLE_WIDTH-1], pose_in.heading}
             - {frame_angle[ANGLE_WIDTH-1], frame_angle};
    end
  end
  for (genvar j = 1; j < NST; j++) begin : g_hd
    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        hd[j] <= hd[j-1];
      end
    end
  end

  // Stage 1: origin difference and reduction of the frame angle into one turn.
  logic signed [15:0]        fa16;
  logic signed [15:0]        r_red;
  logic signed [DW-1:0]      dx1;
  logic signed [DW-1:0]      dy1;
  logic        [R_WIDTH-1:0] r1;

  always_comb begin
    fa16 = {frame_angle[ANGLE_WIDTH-1], frame_angle};
    if (fa16 >= TURN16) begin
      r_red = fa16 - TURN16;
    end else if (fa16 >= 16'sd0) begin
      r_red = fa16;
    end else if (fa16 >= -TURN16) begin
      r_red = fa16 + TURN16;
    end else begin
      r_red = fa16 + TURN16 + TURN16;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dx1 <= {pose_in.pos_x[COORD_WIDTH-1], pose_in.pos_x}
           - {origin_x[COORD_WIDTH-1], origin_x};
      dy1 <= {pose_in.pos_y[COORD_WIDTH-1], pose_in.pos_y}
           - {origin_y[COORD_WIDTH-1], origin_y};
      r1  <= r_red[R_WIDTH-1:0];
    end
  end

  // Stage 2: gain compensation, and the quotient of the angle by ANGLE_DIV.
  logic signed [PW-1:0]       px;
  logic signed [PW-1:0]       py;
  logic        [27:0]         qprod;
  logic signed [CW-1:0]       x2;
  logic signed [CW-1:0]       y2;
  logic        [Q_WIDTH-1:0]  q2;
  logic        [R_WIDTH-1:0]  r2;

  assign px    = dx1 * KINV_Q30;
  assign py    = dy1 * KINV_Q30;
  assign qprod = r1 * 28'(Q_RECIP);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      x2 <= px[CW+SH-1:SH];
      y2 <= py[CW+SH-1:SH];
      q2 <= qprod[Q_SHIFT+Q_WIDTH-1:Q_SHIFT];
      r2 <= r1;
    end
  end

  // Stage 3: binary angle from quotient and remainder.
  logic [R_WIDTH-1:0]  qm;
  logic [R_WIDTH-1:0]  m3;
  logic signed [CW-1:0] x3;
  logic signed [CW-1:0] y3;
  logic [ZW-1:0]        t3;

  assign qm = R_WIDTH'(q2 * R_WIDTH'(ANGLE_DIV));
  assign m3 = r2 - qm;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      x3 <= x2;
      y3 <= y2;
      t3 <= {q2, FRAC_LUT[m3[M_WIDTH-1:0]]};
    end
  end

  // Stage 4: target is minus the angle; fold the back half plane forward.
  logic signed [CW-1:0] x_rot [ROTATION_STAGES+1];
  logic signed [CW-1:0] y_rot [ROTATION_STAGES+1];
  logic        [ZW-1:0] z_rot [ROTATION_STAGES+1];
  logic        [ZW-1:0] z4;
  logic                 fold;

  assign z4   = -t3;
  assign fold = z4[ZW-1] ^ z4[ZW-2];

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      x_rot[0] <= fold ? -x3 : x3;
      y_rot[0] <= fold ? -y3 : y3;
      z_rot[0] <= fold ? z4 + HALF_CIRCLE : z4;
    end
  end

  // CORDIC iterations, one register stage each.
  for (genvar k = 0; k < ROTATION_STAGES; k++) begin : g_rot
    always_ff @(posedge clk) begin
      if (rdy[PRE_STAGES+k]) begin
        if (!z_rot[k][ZW-1]) begin
          x_rot[k+1] <= x_rot[k] - (y_rot[k] >>> k);
          y_rot[k+1] <= y_rot[k] + (x_rot[k] >>> k);
          z_rot[k+1] <= z_rot[k] - ATAN_TABLE[k];
        end else begin
          x_rot[k+1] <= x_rot[k] + (y_rot[k] >>> k);
          y_rot[k+1] <= y_rot[k] - (x_rot[k] >>> k);
          z_rot[k+1] <= z_rot[k] + ATAN_TABLE[k];
        end
      end
    end
  end

  // Output stage: round off the guard bits and saturate.
  function automatic logic signed [COORD_WIDTH-1:0] round_sat(logic signed [CW-1:0] v);
    logic signed [CW:0]   sum;
    logic signed [RW-1:0] sh;
    sum = {v[CW-1], v} + RND;
    sh  = sum[CW:GUARD_BITS];
    if (sh > RW'(SAT_MAX)) begin
      return SAT_MAX;
    end else if (sh < RW'(SAT_MIN)) begin
      return SAT_MIN;
    end
    return sh[COORD_WIDTH-1:0];
  endfunction

  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;

  always_ff @(posedge clk) begin
    if (rdy[OUT_S]) begin
      out_x <= round_sat(x_rot[ROTATION_STAGES]);
      out_y <= round_sat(y_rot[ROTATION_STAGES]);
    end
  end

  assign pose_out.valid       = vld[OUT_S];
  assign pose_out.new_x       = out_x;
  assign pose_out.new_y       = out_y;
  assign pose_out.new_heading = hd[OUT_S];

endmodule

>>> hw/rtl/pft_checker.sv
// ----------------------------------------------------------------------------
// pft_checker: port-level checks for the planar frame transform
// Tracks words in flight and checks reset, occupancy and stall behavior.
// ----------------------------------------------------------------------------
module pft_checker
  import pft_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int DEPTH       = DEF_ROTATION_STAGES + PIPE_EXTRA
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [COORD_WIDTH-1:0]   new_x,
  input logic signed [COORD_WIDTH-1:0]   new_y,
  input logic signed [HEADING_WIDTH-1:0] new_heading
);

  localparam int CNT_W = $clog2(DEPTH + 1) + 1;

  logic             in_acc;
  logic             out_acc;
  logic [CNT_W-1:0] in_flight;

  assign in_acc  = in_valid & in_ready;
  assign out_acc = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // A word leaves only after a word has entered.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_flight != '0)
    else $error("output word with nothing in flight");

  // The pipeline never holds more words than it has stages.
  a_depth: assert property (@(posedge clk) disable iff (rst)
    in_flight <= CNT_W'(DEPTH))
    else $error("more words in flight than pipeline stages");

  // An empty pipeline always takes a word.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    in_flight == '0 |-> in_ready)
    else $error("empty pipeline not ready");

  // A stalled output word holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_x) && $stable(new_y)
                                && $stable(new_heading))
    else $error("stalled output word changed");

endmodule

bind planar_frame_transform pft_checker #(
  .COORD_WIDTH (COORD_WIDTH),
  .DEPTH       (ROTATION_STAGES + pft_pkg::PIPE_EXTRA)
) u_pft_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (pose_in.valid),
  .in_ready    (pose_in.ready),
  .out_valid   (pose_out.valid),
  .out_ready   (pose_out.ready),
  .new_x       (pose_out.new_x),
  .new_y       (pose_out.new_y),
  .new_heading (pose_out.new_heading)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for planar_frame_transform
// Drives poses through the block under a series of frame settings, predicts
// every transformed pose with a bit-exact CORDIC model of its own, and
// compares each output word with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module testbench;
  import pft_pkg::*;

  // Timing of the run.
  localparam int     HALF_PERIOD  = 6;          // 12 ns clock
  localparam int     PIPE_LATENCY = 21;
  localparam int     LONG_HOLD    = 120;        // receiver back-pressure stretch
  localparam longint TIMEOUT_NS   = 4_000_000;  // far beyond the slowest correct run

  // Random part: phases of one frame setting each.
  localparam int RAND_PHASES     = 8;
  localparam int WORDS_PER_PHASE = 210;

  // Fixed-point constants of the predictor.
  localparam longint       TURN_UNITS    = 11520;        // 360 degrees in 1/32 degree
  localparam longint       GAIN_Q30      = 64'h26DD3B6A; // 1/K with 30 fraction bits
  localparam int           GAIN_SHIFT    = 14;           // 30 fraction bits down to 16
  localparam int           ROUND_SHIFT   = 16;           // guard bits dropped at the end
  localparam int           CORDIC_STAGES = 16;
  localparam longint       SAT_HI        = 64'sd8388607;
  localparam longint       SAT_LO        = -64'sd8388608;
  localparam logic [31:0]  HALF_TURN_BA  = 32'h8000_0000;

  // atan(2^-i) as a 32-bit binary angle, one entry per rotation stage.
  localparam logic [31:0] ARCTAN_STEP [0:15] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  // Index with no register behind it; the block must ignore writes to it.
  localparam logic [REG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;

  typedef logic signed [23:0]            coord_t;
  typedef logic signed [ANGLE_WIDTH-1:0] angle_t;

  localparam coord_t COORD_MAX = 24'sh7FFFFF;
  localparam coord_t COORD_MIN = 24'sh800000;
  localparam angle_t ANGLE_MAX = 15'sh3FFF;
  localparam angle_t ANGLE_MIN = 15'sh4000;

  // One transformed pose, as it leaves the block.
  typedef struct {
    logic signed [23:0]              x;
    logic signed [23:0]              y;
    logic signed [HEADING_WIDTH-1:0] heading;
  } pose_word_t;

  // Keeps a copy of the frame registers, turns every accepted pose into the
  // word the block must produce, and checks output words in order.
  class pose_scoreboard;
    coord_t     origin_x;
    coord_t     origin_y;
    angle_t     frame_angle;
    pose_word_t expected_poses[$];
    int         mismatches;

    function new();
      origin_x    = '0;
      origin_y    = '0;
      frame_angle = '0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [REG_INDEX_WIDTH-1:0] index, logic [23:0] data);
      case (index)
        REG_ORIGIN_X:    origin_x    = data;
        REG_ORIGIN_Y:    origin_y    = data;
        REG_FRAME_ANGLE: frame_angle = data[ANGLE_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    function pose_word_t transform_pose(coord_t px, coord_t py, angle_t hd);
      pose_word_t  res;
      longint      dx, dy, turn, x, y, xs, ys;
      logic [31:0] z;
      dx   = longint'(px) - longint'(origin_x);
      dy   = longint'(py) - longint'(origin_y);
      // Rotation angle mod one turn, scaled to a rounded binary angle and negated.
      turn = longint'(frame_angle) % TURN_UNITS;
      if (turn < 0) turn = turn + TURN_UNITS;
      z    = 32'(-(((turn <<< 32) + TURN_UNITS / 2) / TURN_UNITS));
      x    = (dx * GAIN_Q30) >>> GAIN_SHIFT;
      y    = (dy * GAIN_Q30) >>> GAIN_SHIFT;
      // Targets in the left half plane: flip the vector and turn by half a circle.
      if (z[31] ^ z[30]) begin
        x = -x;
        y = -y;
        z = z + HALF_TURN_BA;
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (!z[31]) begin
          x = x - ys;
          y = y + xs;
          z = z - ARCTAN_STEP[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + ARCTAN_STEP[i];
        end
      end
      x = (x + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      y = (y + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      if (x > SAT_HI) x = SAT_HI;
      if (x < SAT_LO) x = SAT_LO;
      if (y > SAT_HI) y = SAT_HI;
      if (y < SAT_LO) y = SAT_LO;
      res.x       = 24'(x);
      res.y       = 24'(y);
      res.heading = HEADING_WIDTH'(longint'(hd) - longint'(frame_angle));
      return res;
    endfunction

    function void note_pose(coord_t px, coord_t py, angle_t hd);
      expected_poses.insert(expected_poses.size(), transform_pose(px, py, hd));
    endfunction

    function void check_result(pose_word_t got);
      pose_word_t exp;
      if (expected_poses.size() == 0) begin
        $display("%0t: unexpected output word x=%0d y=%0d heading=%0d", $time,
                 got.x, got.y, got.heading);
        mismatches++;
        return;
      end
      exp = expected_poses.pop_front();
      if (got.x !== exp.x) begin
        $display("%0t: new_x mismatch, expected %0d, got %0d", $time, exp.x, got.x);
        mismatches++;
      end
      if (got.y !== exp.y) begin
        $display("%0t: new_y mismatch, expected %0d, got %0d", $time, exp.y, got.y);
        mismatches++;
      end
      if (got.heading !== exp.heading) begin
        $display("%0t: new_heading mismatch, expected %0d, got %0d", $time,
                 exp.heading, got.heading);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_poses.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       cfg_write;
  logic [REG_INDEX_WIDTH-1:0] cfg_index;
  logic [23:0]                cfg_data;

  pft_pose_if   pose_ch ();
  pft_result_if res_ch ();

  pose_scoreboard sb = new();

  // Idling switches per phase, and a one-shot request for a long receiver stall.
  bit sender_idles;
  bit receiver_idles;
  bit long_hold_req;

  planar_frame_transform dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pose_in   (pose_ch),
    .pose_out  (res_ch)
  );

  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // Writes the whole frame, holding the write enable high across the burst so
  // it gets exactly one assignment per clock. The upper data bits of the angle
  // write are random because the register keeps only the low 15 bits. A write
  // to the spare index closes the burst and must leave the frame untouched.
  task automatic load_frame(input coord_t ox, input coord_t oy, input angle_t ang);
    logic [23:0] ang_word;
    logic [23:0] junk;
    ang_word = {9'($urandom), ang};
    junk     = 24'($urandom);
    cfg_write <= 1'b1;
    cfg_index <= REG_ORIGIN_X;
    cfg_data  <= ox;
    @(posedge clk);
    sb.write_reg(REG_ORIGIN_X, ox);
    cfg_index <= REG_ORIGIN_Y;
    cfg_data  <= oy;
    @(posedge clk);
    sb.write_reg(REG_ORIGIN_Y, oy);
    cfg_index <= REG_FRAME_ANGLE;
    cfg_data  <= ang_word;
    @(posedge clk);
    sb.write_reg(REG_FRAME_ANGLE, ang_word);
    cfg_index <= REG_SPARE;
    cfg_data  <= junk;
    @(posedge clk);
    sb.write_reg(REG_SPARE, junk);
    cfg_write <= 1'b0;
  endtask

  // Offers one pose after an optional gap and returns at the edge that takes it.
  // With no gap, valid simply stays high into the next word.
  task automatic send_pose(input coord_t px, input coord_t py, input angle_t hd);
    int gap;
    gap = sender_idles ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      pose_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pose_ch.valid   <= 1'b1;
    pose_ch.pos_x   <= px;
    pose_ch.pos_y   <= py;
    pose_ch.heading <= hd;
    do @(posedge clk); while (pose_ch.ready !== 1'b1);
    sb.note_pose(px, py, hd);
  endtask

  // Stops offering and waits until every predicted word has come out. Every
  // pose yields a word, so an empty prediction queue means an empty pipeline.
  task automatic drain_pipeline();
    pose_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Coordinates: the full 24-bit range (so rotated results often saturate),
  // points near a given center (so the rotation itself is exercised), and the
  // two range ends.
  function automatic coord_t pick_coord(coord_t center);
    case ($urandom_range(0, 4))
      0, 1:    return 24'($urandom);
      2:       return center + 24'($urandom_range(0, 131071)) - 24'sd65536;
      3:       return center + 24'($urandom_range(0, 511)) - 24'sd256;
      default: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
    endcase
  endfunction

  function automatic angle_t pick_heading();
    case ($urandom_range(0, 3))
      0, 1, 2: return 15'($urandom);
      default: return $urandom_range(0, 1) ? 15'sd11520 : -15'sd11520;
    endcase
  endfunction

  // Frame angles: any 15-bit value, values within one turn either way, values
  // right at or next to the quadrant boundaries, and zero.
  function automatic angle_t pick_angle();
    int k;
    case ($urandom_range(0, 3))
      0: return 15'($urandom);
      1: return 15'(int'($urandom_range(0, 23040)) - 11520);
      2: begin
        k = int'($urandom_range(0, 10)) - 5;
        return 15'(k * 2880 + int'($urandom_range(0, 2)) - 1);
      end
      default: return '0;
    endcase
  endfunction

  // Output side: takes words with a random stall before each one, or none at
  // all in the phases without idling. The long hold-off is counted here, while
  // the sender keeps offering, so the pipeline fills and blocks its input.
  initial begin : result_sink
    pose_word_t got;
    int         stall;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = receiver_idles ? $urandom_range(0, 9) : 0;
      if (long_hold_req) begin
        stall         = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      got.x       = res_ch.new_x;
      got.y       = res_ch.new_y;
      got.heading = res_ch.new_heading;
      sb.check_result(got);
    end
  end

  // Stimulus: a directed part at the reset frame, at the range ends and at the
  // quadrant boundaries, then random phases with a fresh frame each.
  initial begin : stimulus
    angle_t quad_angles [6];
    coord_t ox, oy;
    quad_angles = '{15'sd2880, 15'sd5760, 15'sd8640, -15'sd2880, 15'sd11520, -15'sd11520};

    rst             <= 1'b1;
    cfg_write       <= 1'b0;
    cfg_index       <= REG_ORIGIN_X;
    cfg_data        <= '0;
    pose_ch.valid   <= 1'b0;
    pose_ch.pos_x   <= '0;
    pose_ch.pos_y   <= '0;
    pose_ch.heading <= '0;
    sender_idles    = 1'b0;
    receiver_idles  = 1'b0;
    long_hold_req   = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset frame: the block must work with its cleared registers.
    send_pose('0, '0, '0);
    send_pose(COORD_MAX, COORD_MAX, ANGLE_MAX);
    send_pose(COORD_MIN, COORD_MIN, ANGLE_MIN);
    send_pose(COORD_MAX, COORD_MIN, '0);
    drain_pipeline();

    // Origin at the negative end and an angle beyond a full turn: the
    // differences need the extra bit and the rotated values saturate.
    load_frame(COORD_MIN, COORD_MIN, ANGLE_MAX);
    send_pose(COORD_MAX, COORD_MAX, ANGLE_MAX);
    send_pose(COORD_MAX, COORD_MIN, ANGLE_MIN);
    send_pose('0, '0, '0);
    drain_pipeline();

    // Origin at the positive end and the most negative angle; the heading
    // differences reach the top end of the 16-bit result.
    load_frame(COORD_MAX, COORD_MAX, ANGLE_MIN);
    send_pose(COORD_MIN, COORD_MIN, ANGLE_MIN);
    send_pose(COORD_MIN, COORD_MAX, ANGLE_MAX);
    drain_pipeline();

    // Quarter turns and whole turns, where the quadrant fold switches.
    foreach (quad_angles[i]) begin
      load_frame(24'sd2560, -24'sd1280, quad_angles[i]);
      send_pose(24'sd3560, -24'sd1280, '0);
      send_pose(24'sd2060, 24'sd5720, 15'sd11520);
      drain_pipeline();
    end

    // Random phases; idling on each side follows the phase number, so phases
    // 0 and 4 run back to back on both sides. Phase 0 also carries the long
    // receiver stall.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      sender_idles   = phase[0];
      receiver_idles = phase[1];
      ox = pick_coord('0);
      oy = pick_coord('0);
      load_frame(ox, oy, pick_angle());
      if (phase == 0) long_hold_req = 1'b1;
      repeat (WORDS_PER_PHASE) send_pose(pick_coord(ox), pick_coord(oy), pick_heading());
      drain_pipeline();
    end

    // Give a stray extra word time to show up before the verdict.
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
